>>> design/mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;

    localparam int FRAC_BITS  = 11;
    localparam int DATA_WIDTH = 16;
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
    localparam int OPW        = 24;
    localparam int MW         = 32;
    localparam int NUM_W      = 9;

    // operation codes of an input item
    localparam logic [1:0] MODE_INFER = 2'd0;
    localparam logic [1:0] MODE_TRAIN = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x_first;
        logic signed [15:0] x_second;
        logic [11:0]        target;
        logic [3:0]         weight_index;
        logic signed [15:0] weight_value;
    } t_in_item;

    typedef struct packed {
        logic [11:0] prediction;
        logic [11:0] squared_error;
    } t_out_item;

    typedef logic [11:0] t_sig_rom [SIG_DEPTH];

    // sigmoid of a non-negative Q30 argument, Q.FRAC_BITS result
    function automatic logic [11:0] sig_pos(input longint unsigned u);
        longint unsigned v, v2, v3, v4, r, d, rem, q, s;
        v  = u >> 8;
        v2 = (v * v) >> 30;
        v3 = (v2 * v) >> 30;
        v4 = (v3 * v) >> 30;
        r  = (64'd1 << 30) - v + v2 / 2 - v3 / 6 + v4 / 24;
        for (int i = 0; i < 8; i++) begin
            r = (r * r) >> 30;
        end
        // restoring long division of 2^60 by (2^30 + r)
        d   = (64'd1 << 30) + r;
        rem = 0;
        q   = 0;
        for (int i = 60; i >= 0; i--) begin
            rem = (rem << 1) | ((i == 60) ? 64'd1 : 64'd0);
            if (rem >= d) begin
                rem = rem - d;
                q   = q | (64'd1 << i);
            end
        end
        s = (q + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return s[11:0];
    endfunction

    function automatic t_sig_rom build_sig_rom();
        t_sig_rom rom;
        longint c;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            c = -(longint'(8) << 30)
                + ((longint'(2 * k + 1)) * (longint'(8) << 30)) / SIG_DEPTH;
            if (c >= 0) begin
                rom[k] = sig_pos(longint'(c));
            end else begin
                rom[k] = 12'(13'(1 << FRAC_BITS) - 13'(sig_pos(longint'(-c))));
            end
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

    // saturate a widened weight sum to the weight width
    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [MW+1:0] v);
        logic signed [MW+1:0] hi, lo;
        hi = (MW+2)'((64'd1 << (DATA_WIDTH - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[DATA_WIDTH-1:0];
        if (v < lo) return lo[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/mlp_2_2_1_sgd_trainer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Load and spare items finish in the decode step, infer after the forward pass, train
// after the backprop and weight-update steps as well. One item in flight; the input
// stalls until its result is registered. All multiplies go through one shared 24x24
// multiplier stepped by the sequencer.
// Reset (synchronous, active low): weights cleared to zero, learning rate 205 (0.1),
// no result pending.
module mlp_2_2_1_sgd_trainer_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mst_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mst_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [11:0]       i_cfg_data
);
    import mst_pkg::*;

    localparam logic [4:0] S_DEC  = 5'd0,  S_H1A = 5'd1,  S_H1B = 5'd2,  S_H2A = 5'd3;
    localparam logic [4:0] S_H2B  = 5'd4,  S_YA  = 5'd5,  S_YB  = 5'd6,  S_SQ  = 5'd7;
    localparam logic [4:0] S_DSY  = 5'd8,  S_DO  = 5'd9,  S_T1  = 5'd10, S_U1  = 5'd11;
    localparam logic [4:0] S_DH1  = 5'd12, S_T2  = 5'd13, S_U2  = 5'd14, S_DH2 = 5'd15;
    localparam logic [4:0] S_SO   = 5'd16, S_SH1 = 5'd17, S_SH2 = 5'd18, S_W4  = 5'd19;
    localparam logic [4:0] S_W5   = 5'd20, S_W0  = 5'd21, S_W1  = 5'd22, S_W2  = 5'd23;
    localparam logic [4:0] S_W3   = 5'd24, S_FIN = 5'd25;

    localparam logic signed [13:0] ONE14 = 14'(1 << FRAC_BITS);

    logic                         r_busy;
    logic [4:0]                   r_step;
    t_in_item                     r_item;
    logic [11:0]                  r_lr;
    logic signed [DATA_WIDTH-1:0] r_w [NUM_W];
    logic signed [OPW-1:0]        r_acc, r_t, r_u, r_dout, r_dh1, r_dh2, r_sout, r_sh1, r_sh2;
    logic [11:0]                  r_h1, r_h2, r_y;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic signed [OPW-1:0] w_a, w_b, w_z;
    logic signed [MW-1:0]  w_m;
    logic [11:0]           w_sig;
    logic signed [13:0]    w_err;
    logic                  w_out_free;
    logic                  w_done;

    mst_mul_unit u_mul (.i_a(w_a), .i_b(w_b), .o_m(w_m));
    mst_sigmoid  u_sig (.i_z(w_z), .o_s(w_sig));

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_err       = $signed({2'b00, r_item.target}) - $signed({2'b00, r_y});

    // result register loads this cycle
    always_comb begin
        w_done = 1'b0;
        if (r_busy && w_out_free) begin
            case (r_step)
                S_DEC:   w_done = (r_item.mode != MODE_INFER) && (r_item.mode != MODE_TRAIN);
                S_DSY:   w_done = (r_item.mode == MODE_INFER);
                S_FIN:   w_done = 1'b1;
                default: w_done = 1'b0;
            endcase
        end
    end

    // operand selection for the shared multiplier and sigmoid argument
    always_comb begin
        w_a = '0;
        w_b = '0;
        w_z = '0;
        case (r_step)
            S_H1A: begin w_a = OPW'(r_item.x_first);  w_b = OPW'(r_w[0]); end
            S_H1B: begin w_a = OPW'(r_item.x_second); w_b = OPW'(r_w[1]); end
            S_H2A: begin w_a = OPW'(r_item.x_first);  w_b = OPW'(r_w[2]);
                         w_z = r_acc + OPW'(r_w[6]); end
            S_H2B: begin w_a = OPW'(r_item.x_second); w_b = OPW'(r_w[3]); end
            S_YA:  begin w_a = OPW'({1'b0, r_h1});    w_b = OPW'(r_w[4]);
                         w_z = r_acc + OPW'(r_w[7]); end
            S_YB:  begin w_a = OPW'({1'b0, r_h2});    w_b = OPW'(r_w[5]); end
            S_SQ:  begin w_z = r_acc + OPW'(r_w[8]); end
            S_DSY: begin w_a = OPW'({1'b0, r_y});     w_b = OPW'(ONE14 - $signed({2'b00, r_y})); end
            S_DO:  begin w_a = OPW'(w_err);           w_b = r_t; end
            S_T1:  begin w_a = r_dout;                w_b = OPW'(r_w[4]); end
            S_U1:  begin w_a = OPW'({1'b0, r_h1});    w_b = OPW'(ONE14 - $signed({2'b00, r_h1})); end
            S_DH1: begin w_a = r_t;                   w_b = r_u; end
            S_T2:  begin w_a = r_dout;                w_b = OPW'(r_w[5]); end
            S_U2:  begin w_a = OPW'({1'b0, r_h2});    w_b = OPW'(ONE14 - $signed({2'b00, r_h2})); end
            S_DH2: begin w_a = r_t;                   w_b = r_u; end
            S_SO:  begin w_a = OPW'({1'b0, r_lr});    w_b = r_dout; end
            S_SH1: begin w_a = OPW'({1'b0, r_lr});    w_b = r_dh1; end
            S_SH2: begin w_a = OPW'({1'b0, r_lr});    w_b = r_dh2; end
            S_W4:  begin w_a = r_sout;                w_b = OPW'({1'b0, r_h1}); end
            S_W5:  begin w_a = r_sout;                w_b = OPW'({1'b0, r_h2}); end
            S_W0:  begin w_a = r_sh1;                 w_b = OPW'(r_item.x_first); end
            S_W1:  begin w_a = r_sh1;                 w_b = OPW'(r_item.x_second); end
            S_W2:  begin w_a = r_sh2;                 w_b = OPW'(r_item.x_first); end
            S_W3:  begin w_a = r_sh2;                 w_b = OPW'(r_item.x_second); end
            // squared error on the last pass, y still held
            S_FIN: begin w_a = OPW'(w_err);           w_b = OPW'(w_err); end
            default: begin end
        endcase
    end

    // sequencer, weights and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= S_DEC;
            r_out_valid <= 1'b0;
            r_lr        <= 12'd205;
            for (int i = 0; i < NUM_W; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_lr <= i_cfg_data;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (!r_busy) begin
                if (i_in_valid) begin
                    r_item <= i_in_item;
                    r_busy <= 1'b1;
                    r_step <= S_DEC;
                end
            end else begin
                case (r_step)
                    S_DEC: begin
                        if (r_item.mode == MODE_INFER || r_item.mode == MODE_TRAIN) begin
                            r_step <= S_H1A;
                        end else if (w_out_free) begin
                            if (r_item.mode == MODE_LOAD && r_item.weight_index < 4'(NUM_W)) begin
                                r_w[r_item.weight_index] <= r_item.weight_value;
                            end
                            r_out  <= '0;
                            r_busy <= 1'b0;
                        end
                    end
                    S_H1A, S_H2A: begin
                        r_acc <= OPW'(w_m);
                        if (r_step == S_H2A) r_h1 <= w_sig;
                        r_step <= r_step + 5'd1;
                    end
                    S_H1B, S_H2B, S_YB: begin
                        r_acc  <= r_acc + OPW'(w_m);
                        r_step <= r_step + 5'd1;
                    end
                    S_YA: begin
                        r_h2   <= w_sig;
                        r_acc  <= OPW'(w_m);
                        r_step <= S_YB;
                    end
                    S_SQ: begin
                        // latch y, then infer finishes or train goes on
                        r_y    <= w_sig;
                        r_step <= S_DSY;
                    end
                    S_DSY: begin
                        if (r_item.mode == MODE_INFER) begin
                            if (w_out_free) begin
                                r_out.prediction    <= r_y;
                                r_out.squared_error <= '0;
                                r_busy              <= 1'b0;
                            end
                        end else begin
                            r_t    <= OPW'(w_m);
                            r_step <= S_DO;
                        end
                    end
                    S_DO: begin
                        r_dout <= OPW'(w_m);
                        r_step <= S_T1;
                    end
                    S_T1, S_T2: begin
                        r_t    <= OPW'(w_m);
                        r_step <= r_step + 5'd1;
                    end
                    S_U1, S_U2: begin
                        r_u    <= OPW'(w_m);
                        r_step <= r_step + 5'd1;
                    end
                    S_DH1: begin
                        r_dh1  <= OPW'(w_m);
                        r_step <= S_T2;
                    end
                    S_DH2: begin
                        r_dh2  <= OPW'(w_m);
                        r_step <= S_SO;
                    end
                    S_SO: begin
                        r_sout <= OPW'(w_m);
                        r_step <= S_SH1;
                    end
                    S_SH1: begin
                        r_sh1  <= OPW'(w_m);
                        r_step <= S_SH2;
                    end
                    S_SH2: begin
                        r_sh2  <= OPW'(w_m);
                        r_step <= S_W4;
                    end
                    S_W4: begin
                        r_w[4] <= sat_w((MW+2)'(r_w[4]) + (MW+2)'(w_m));
                        r_w[8] <= sat_w((MW+2)'(r_w[8]) + (MW+2)'(r_sout));
                        r_step <= S_W5;
                    end
                    S_W5: begin
                        r_w[5] <= sat_w((MW+2)'(r_w[5]) + (MW+2)'(w_m));
                        r_step <= S_W0;
                    end
                    S_W0: begin
                        r_w[0] <= sat_w((MW+2)'(r_w[0]) + (MW+2)'(w_m));
                        r_w[6] <= sat_w((MW+2)'(r_w[6]) + (MW+2)'(r_sh1));
                        r_step <= S_W1;
                    end
                    S_W1: begin
                        r_w[1] <= sat_w((MW+2)'(r_w[1]) + (MW+2)'(w_m));
                        r_step <= S_W2;
                    end
                    S_W2: begin
                        r_w[2] <= sat_w((MW+2)'(r_w[2]) + (MW+2)'(w_m));
                        r_w[7] <= sat_w((MW+2)'(r_w[7]) + (MW+2)'(r_sh2));
                        r_step <= S_W3;
                    end
                    S_W3: begin
                        r_w[3] <= sat_w((MW+2)'(r_w[3]) + (MW+2)'(w_m));
                        r_step <= S_FIN;
                    end
                    S_FIN: begin
                        if (w_out_free) begin
                            r_out.prediction    <= r_y;
                            // err^2 from the multiplier, clipped to 4095
                            r_out.squared_error <= (w_m > MW'(4095)) ? 12'hFFF : w_m[11:0];
                            r_busy              <= 1'b0;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

>>> design/mst_mul_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module mst_mul_unit (
    input  wire logic signed [mst_pkg::OPW-1:0] i_a,
    input  wire logic signed [mst_pkg::OPW-1:0] i_b,
    output logic signed [mst_pkg::MW-1:0]       o_m
);
    import mst_pkg::*;

    logic signed [2*OPW-1:0] w_p;

    // fixed-point product, low fraction bits dropped (floor)
    assign w_p = i_a * i_b;
    assign o_m = MW'(w_p >>> FRAC_BITS);

endmodule
`default_nettype wire

>>> design/mst_sigmoid.sv
`timescale 1ns / 1ps
`default_nettype none
module mst_sigmoid (
    input  wire logic signed [mst_pkg::OPW-1:0] i_z,
    output logic [11:0]                         o_s
);
    import mst_pkg::*;

    localparam int LIM_W = FRAC_BITS + 4;
    localparam logic signed [OPW-1:0] LIM = OPW'(1 << (FRAC_BITS + 3));

    logic signed [OPW-1:0] w_sat;
    logic [OPW-1:0]        w_off;

    // clamp to [-8, 8) and take the top bits of the offset as index
    always_comb begin
        w_sat = i_z;
        if (i_z < -LIM)       w_sat = -LIM;
        else if (i_z > LIM - 1) w_sat = LIM - 1;
        w_off = OPW'(w_sat + LIM);
        o_s   = SIG_ROM[w_off[LIM_W-1 -: SIG_IDX_W]];
    end

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mst_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [11:0] i_cfg_data;

    mlp_2_2_1_sgd_trainer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [11:0]        sig_table [SIG_DEPTH];
    longint             net_w [NUM_W];
    longint             rate;
    t_out_item          pending_q [$];

    int errors;
    int items_sent;
    int results_seen;
    int trains_sent;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sigmoid table entry for one non-negative Q30 argument
    function automatic longint unsigned sig_of_pos(input longint unsigned u);
        longint unsigned v, v2, v3, v4, r, s;
        v  = u >> 8;
        v2 = (v * v) >> 30;
        v3 = (v2 * v) >> 30;
        v4 = (v3 * v) >> 30;
        r  = (64'd1 << 30) - v + v2 / 2 - v3 / 6 + v4 / 24;
        for (int i = 0; i < 8; i++) r = (r * r) >> 30;
        s = (64'd1 << 60) / ((64'd1 << 30) + r);
        return (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    task automatic fill_sig_table();
        longint c;
        for (int k = 0; k < SIG_DEPTH; k++) begin
            c = -(longint'(8) << 30) + (longint'(2 * k + 1) * (longint'(8) << 30)) / SIG_DEPTH;
            if (c >= 0) sig_table[k] = 12'(sig_of_pos(c));
            else sig_table[k] = 12'((1 << FRAC_BITS) - sig_of_pos(-c));
        end
    endtask

    // product with low fraction bits dropped (floor)
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sigmoid_q(input longint z);
        longint lim;
        longint idx;
        lim = longint'(8) << FRAC_BITS;
        if (z < -lim) z = -lim;
        if (z > lim - 1) z = lim - 1;
        idx = ((z + lim) * SIG_DEPTH) >>> (FRAC_BITS + 4);
        if (idx >= SIG_DEPTH) idx = SIG_DEPTH - 1;
        return longint'(sig_table[idx]);
    endfunction

    function automatic longint dsig_q(input longint a);
        return qmul(a, (longint'(1) << FRAC_BITS) - a);
    endfunction

    // forward pass, and for training backprop plus SGD update
    task automatic predict_network(input t_in_item it);
        t_out_item r;
        longint x1, x2, tg, h1, h2, y, e, sq, d_o, d1, d2, so, s1, s2;
        r  = '0;
        x1 = longint'(it.x_first);
        x2 = longint'(it.x_second);
        tg = longint'(it.target);
        if (it.mode == MODE_LOAD) begin
            if (it.weight_index < NUM_W) net_w[it.weight_index] = longint'(it.weight_value);
        end else if (it.mode == MODE_INFER || it.mode == MODE_TRAIN) begin
            h1 = sigmoid_q(qmul(x1, net_w[0]) + qmul(x2, net_w[1]) + net_w[6]);
            h2 = sigmoid_q(qmul(x1, net_w[2]) + qmul(x2, net_w[3]) + net_w[7]);
            y  = sigmoid_q(qmul(h1, net_w[4]) + qmul(h2, net_w[5]) + net_w[8]);
            r.prediction = 12'(y);
            if (it.mode == MODE_TRAIN) begin
                e   = tg - y;
                sq  = qmul(e, e);
                d_o = qmul(e, dsig_q(y));
                d1  = qmul(qmul(d_o, net_w[4]), dsig_q(h1));
                d2  = qmul(qmul(d_o, net_w[5]), dsig_q(h2));
                so  = qmul(rate, d_o);
                s1  = qmul(rate, d1);
                s2  = qmul(rate, d2);
                if (sq > 4095) sq = 4095;
                r.squared_error = 12'(sq);
                net_w[4] = clamp16(net_w[4] + qmul(so, h1));
                net_w[5] = clamp16(net_w[5] + qmul(so, h2));
                net_w[8] = clamp16(net_w[8] + so);
                net_w[0] = clamp16(net_w[0] + qmul(s1, x1));
                net_w[1] = clamp16(net_w[1] + qmul(s1, x2));
                net_w[2] = clamp16(net_w[2] + qmul(s2, x1));
                net_w[3] = clamp16(net_w[3] + qmul(s2, x2));
                net_w[6] = clamp16(net_w[6] + s1);
                net_w[7] = clamp16(net_w[7] + s2);
            end
        end
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // send one item, prediction made at acceptance; valid stays up until idled
    task automatic send_item(input t_in_item it);
        while (($urandom_range(99) < send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_network(it);
        items_sent++;
        if (it.mode == MODE_TRAIN) trains_sent++;
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("unexpected result item");
                errors++;
            end else begin
                w = pending_q.pop_front();
                if (o_out_item.prediction !== w.prediction)
                    report_mismatch("prediction", o_out_item.prediction, w.prediction);
                if (o_out_item.squared_error !== w.squared_error)
                    report_mismatch("squared_error", o_out_item.squared_error,
                                    w.squared_error);
            end
            results_seen++;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [11:0] v);
        @(negedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        rate = longint'(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(input logic [1:0] m, input int a, input int b,
                                           input int tg, input int wi, input int wv);
        t_in_item it;
        it.mode = m;
        it.x_first = 16'(a);
        it.x_second = 16'(b);
        it.target = 12'(tg);
        it.weight_index = 4'(wi);
        it.weight_value = 16'(wv);
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int k;
        it = t_in_item'({$urandom, $urandom});
        k = $urandom_range(99);
        if (k < 45) it.mode = MODE_TRAIN;
        else if (k < 75) it.mode = MODE_INFER;
        else if (k < 95) it.mode = MODE_LOAD;
        else it.mode = MODE_SPARE;
        // mostly modest inputs and sensible targets so training stays live
        if ($urandom_range(3) != 0) begin
            it.x_first  = 16'($signed($urandom_range(8192)) - 4096);
            it.x_second = 16'($signed($urandom_range(8192)) - 4096);
            it.target   = 12'($urandom_range(2048));
            it.weight_index = 4'($urandom_range(8));
            it.weight_value = 16'($signed($urandom_range(8192)) - 4096);
        end
        return it;
    endfunction

    task automatic test_directed();
        send_item(make_item(MODE_INFER, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_TRAIN, 32767, -32768, 2048, 0, 0));
        for (int i = 0; i < 9; i++)
            send_item(make_item(MODE_LOAD, 0, 0, 0, i, (i % 2) ? -32768 : 32767));
        send_item(make_item(MODE_LOAD, 0, 0, 0, 9, 1234));       // index out of range
        send_item(make_item(MODE_LOAD, 0, 0, 0, 15, -1));
        send_item(make_item(MODE_SPARE, 100, 100, 100, 3, 3));   // unused mode
        send_item(make_item(MODE_INFER, 32767, 32767, 0, 0, 0));
        send_item(make_item(MODE_TRAIN, -32768, 32767, 4095, 0, 0)); // target above one
        send_item(make_item(MODE_TRAIN, 2048, 2048, 0, 0, 0));
        send_item(make_item(MODE_LOAD, 0, 0, 0, 4, 0));
        send_item(make_item(MODE_TRAIN, -1, 1, 1024, 0, 0));
        send_item(make_item(MODE_INFER, -32768, -32768, 0, 0, 0));
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_item(random_item());
        drain();
    endtask

    task automatic test_rates();
        logic [11:0] rates [4] = '{12'd0, 12'd2048, 12'd4095, 12'd205};
        foreach (rates[i]) begin
            write_rate(rates[i]);
            test_random(50, 20, 20);
        end
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (20) send_item(random_item());
        join
        drain();
    endtask

    initial begin
        errors = 0; items_sent = 0; results_seen = 0; trains_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_item = '0; i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        fill_sig_table();
        foreach (net_w[i]) net_w[i] = 0;
        rate = 205;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(200, 0, 0);
        test_random(200, 73, 0);
        test_random(200, 0, 73);
        test_random(150, 22, 22);
        test_backpressure();
        test_rates();

        $display("sent %0d items (%0d training steps), checked %0d results",
                 items_sent, trains_sent, results_seen);
        $display("learning rate swept over zero, one, the top code and the default");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
